// File: sv/lidar_point_to_pixel_projection_top_assert.svh
// Assertion macros used by the checker file lpp_chk.sv.
// Clock is "clock", reset is "reset" at the place of use.
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_TOP_ASSERT_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication, idle in reset
`define LPP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle in reset
`define LPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold on the cycle after reset
`define LPP_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// File: sv/lpp_pkg.sv
// Shared types and constants for the point-to-pixel projection block.
// No dependencies.
package lpp_pkg;

   localparam int XYZ_W  = 51;   // camera-frame X/Y/Z, Q.30
   localparam int REM_W  = 53;   // divider partial remainder
   localparam int QW     = 27;   // quotient bits, Q3.24 magnitude
   localparam int XN_W   = 28;   // signed normalized coordinate
   localparam int FAC_W  = 36;   // clamped distortion factor, Q.24
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;

   localparam logic signed [XN_W-1:0]  XN_MAX  = 28'sd134217727;
   localparam logic signed [FAC_W-1:0] FAC_MAX = 36'sd17179869183;

   typedef enum logic [2:0] {
      REG_S0_A, REG_S0_B, REG_S0_C,
      REG_S1_A, REG_S1_B, REG_S1_C,
      REG_LENS, REG_PP
   } reg_idx_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_XFORM = 2'd1;
   localparam logic [1:0] ST_DEPTH    = 2'd2;
   localparam logic [1:0] ST_SAT      = 2'd3;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               sensor_select;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] err;
      logic       negx;
      logic       negy;
      logic       satx;
      logic       saty;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] remx;
      logic [REM_W-1:0] remy;
      logic [REM_W-1:0] d8;
      logic [QW-1:0]    qx;
      logic [QW-1:0]    qy;
      side_type         side;
   } div_stage_type;

endpackage

// File: sv/lpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes (x and y).
// Depends on lpp_pkg.
module lpp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  lpp_pkg::div_stage_type in_data,
   output logic                  out_valid,
   output lpp_pkg::div_stage_type out_data
);

   localparam int QW = lpp_pkg::QW;

   logic [QW-1:0]          valid_ff;
   lpp_pkg::div_stage_type data_ff [QW];

   // remainder doubles each step against 8*den, so quotient = floor(a*2^24/den)
   function automatic lpp_pkg::div_stage_type div_step(input lpp_pkg::div_stage_type s);
      lpp_pkg::div_stage_type r;
      logic [lpp_pkg::REM_W-1:0] tx;
      logic [lpp_pkg::REM_W-1:0] ty;
      r  = s;
      tx = s.remx << 1;
      ty = s.remy << 1;
      if (tx >= s.d8) begin
         r.remx = tx - s.d8;
         r.qx   = {s.qx[QW-2:0], 1'b1};
      end else begin
         r.remx = tx;
         r.qx   = {s.qx[QW-2:0], 1'b0};
      end
      if (ty >= s.d8) begin
         r.remy = ty - s.d8;
         r.qy   = {s.qy[QW-2:0], 1'b1};
      end else begin
         r.remy = ty;
         r.qy   = {s.qy[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= div_step(in_data);
         for (int k = 1; k < QW; k++) begin
            data_ff[k] <= div_step(data_ff[k-1]);
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_data  = data_ff[QW-1];

endmodule

// File: sv/lidar_point_to_pixel_projection_top.sv
// Lidar point to camera pixel projection, pinhole model with k1/k2 radial distortion.
// Throughput: one transaction per cycle while req_stall is low; the 27-stage divider sets the depth.
// req_stall rises only while the output skid register is occupied.
// Reset (synchronous): clears all configuration registers and pipeline valid bits.
// Depends on lpp_pkg and lpp_div.
module lidar_point_to_pixel_projection_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lpp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lpp_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpp_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [lpp_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [lpp_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int XW  = lpp_pkg::XYZ_W;
   localparam int RW  = lpp_pkg::REM_W;
   localparam int NW  = lpp_pkg::XN_W;
   localparam int FW  = lpp_pkg::FAC_W;

   typedef struct packed {
      logic signed [NW-1:0] xn;
      logic signed [NW-1:0] yn;
      logic [1:0]           err;
      logic                 sat;
   } post_type;

   function automatic logic signed [15:0] slot(input logic [63:0] r, input int i);
      return $signed(r[16*i +: 16]);
   endfunction

   // ---------------- configuration ----------------
   logic [63:0] s0a_ff, s0b_ff, s0c_ff, s1a_ff, s1b_ff, s1c_ff, lens_ff, pp_ff;
   lpp_pkg::reg_idx_type csr_idx;

   assign csr_idx    = lpp_pkg::reg_idx_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0a_ff  <= '0;
         s0b_ff  <= '0;
         s0c_ff  <= '0;
         s1a_ff  <= '0;
         s1b_ff  <= '0;
         s1c_ff  <= '0;
         lens_ff <= '0;
         pp_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            lpp_pkg::REG_S0_A: s0a_ff  <= csr_pwdata;
            lpp_pkg::REG_S0_B: s0b_ff  <= csr_pwdata;
            lpp_pkg::REG_S0_C: s0c_ff  <= csr_pwdata;
            lpp_pkg::REG_S1_A: s1a_ff  <= csr_pwdata;
            lpp_pkg::REG_S1_B: s1b_ff  <= csr_pwdata;
            lpp_pkg::REG_S1_C: s1c_ff  <= csr_pwdata;
            lpp_pkg::REG_LENS: lens_ff <= csr_pwdata;
            lpp_pkg::REG_PP:   pp_ff   <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         lpp_pkg::REG_S0_A: csr_prdata = s0a_ff;
         lpp_pkg::REG_S0_B: csr_prdata = s0b_ff;
         lpp_pkg::REG_S0_C: csr_prdata = s0c_ff;
         lpp_pkg::REG_S1_A: csr_prdata = s1a_ff;
         lpp_pkg::REG_S1_B: csr_prdata = s1b_ff;
         lpp_pkg::REG_S1_C: csr_prdata = s1c_ff;
         lpp_pkg::REG_LENS: csr_prdata = lens_ff;
         lpp_pkg::REG_PP:   csr_prdata = pp_ff;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic skid_valid_ff;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- S1: transform select, rotation products ----------------
   logic [1:0]  vbits;
   logic        id, novalid;
   logic [63:0] xa, xb, xc;
   logic signed [47:0] s1_p_in [9];
   logic signed [47:0] s1_p_ff [9];
   logic signed [15:0] s1_t_ff [3];
   logic        s1_nov_ff, s1_valid_ff;

   always_comb begin
      vbits   = pp_ff[49:48];
      novalid = (vbits == 2'b00);
      // fall back to the other sensor when the selected one is not valid
      id      = vbits[req_data.sensor_select] ? req_data.sensor_select
                                              : !req_data.sensor_select;
      xa      = id ? s1a_ff : s0a_ff;
      xb      = id ? s1b_ff : s0b_ff;
      xc      = id ? s1c_ff : s0c_ff;
      s1_p_in[0] = slot(xa, 0) * req_data.point_x;
      s1_p_in[1] = slot(xa, 1) * req_data.point_y;
      s1_p_in[2] = slot(xa, 2) * req_data.point_z;
      s1_p_in[3] = slot(xa, 3) * req_data.point_x;
      s1_p_in[4] = slot(xb, 0) * req_data.point_y;
      s1_p_in[5] = slot(xb, 1) * req_data.point_z;
      s1_p_in[6] = slot(xb, 2) * req_data.point_x;
      s1_p_in[7] = slot(xb, 3) * req_data.point_y;
      s1_p_in[8] = slot(xc, 0) * req_data.point_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff   <= s1_p_in;
         s1_t_ff[0] <= slot(xc, 1);
         s1_t_ff[1] <= slot(xc, 2);
         s1_t_ff[2] <= slot(xc, 3);
         s1_nov_ff <= novalid;
      end
   end

   // ---------------- S2: sums, camera-frame point in Q.30 ----------------
   logic signed [XW-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic                 s2_nov_ff, s2_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ff <= XW'(s1_p_ff[0]) + XW'(s1_p_ff[1]) + XW'(s1_p_ff[2])
                    + (XW'(s1_t_ff[0]) <<< 22);
         s2_y_ff <= XW'(s1_p_ff[3]) + XW'(s1_p_ff[4]) + XW'(s1_p_ff[5])
                    + (XW'(s1_t_ff[1]) <<< 22);
         s2_z_ff <= XW'(s1_p_ff[6]) + XW'(s1_p_ff[7]) + XW'(s1_p_ff[8])
                    + (XW'(s1_t_ff[2]) <<< 22);
         s2_nov_ff <= s1_nov_ff;
      end
   end

   // ---------------- S3: divider setup ----------------
   lpp_pkg::div_stage_type s3_in, s3_ff;
   logic                   s3_valid_ff;
   logic signed [XW-1:0]   ax, ay;

   always_comb begin
      ax = s2_x_ff[XW-1] ? -s2_x_ff : s2_x_ff;
      ay = s2_y_ff[XW-1] ? -s2_y_ff : s2_y_ff;
      s3_in.remx = RW'(ax[47:0]);
      s3_in.remy = RW'(ay[47:0]);
      s3_in.d8   = RW'({s2_z_ff[47:0], 3'b000});
      s3_in.qx   = '0;
      s3_in.qy   = '0;
      s3_in.side.negx = s2_x_ff[XW-1];
      s3_in.side.negy = s2_y_ff[XW-1];
      s3_in.side.satx = (s3_in.remx >= s3_in.d8);
      s3_in.side.saty = (s3_in.remy >= s3_in.d8);
      if (s2_nov_ff) begin
         s3_in.side.err = lpp_pkg::ST_NO_XFORM;
      end else if (s2_z_ff[XW-1] || (s2_z_ff == '0)) begin
         s3_in.side.err = lpp_pkg::ST_DEPTH;
      end else begin
         s3_in.side.err = lpp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- divider ----------------
   logic                   dv_valid;
   lpp_pkg::div_stage_type dv_data;

   lpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s3_valid_ff),
      .in_data  (s3_ff),
      .out_valid(dv_valid),
      .out_data (dv_data)
   );

   // ---------------- M1..M9: distortion and pixel mapping ----------------
   logic signed [15:0] k1, k2, fx, fy, cx, cy;
   assign k1 = slot(lens_ff, 0);
   assign k2 = slot(lens_ff, 1);
   assign fx = slot(lens_ff, 2);
   assign fy = slot(lens_ff, 3);
   assign cx = slot(pp_ff, 0);
   assign cy = slot(pp_ff, 1);

   post_type m1_in;
   post_type m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff, m7_ff, m8_ff;
   logic m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff;
   logic m5_valid_ff, m6_valid_ff, m7_valid_ff, m8_valid_ff, m9_valid_ff;
   logic signed [NW-1:0] magx, magy;

   always_comb begin
      magx = dv_data.side.satx ? lpp_pkg::XN_MAX : $signed({1'b0, dv_data.qx});
      magy = dv_data.side.saty ? lpp_pkg::XN_MAX : $signed({1'b0, dv_data.qy});
      m1_in.xn  = dv_data.side.negx ? -magx : magx;
      m1_in.yn  = dv_data.side.negy ? -magy : magy;
      m1_in.err = dv_data.side.err;
      m1_in.sat = dv_data.side.satx || dv_data.side.saty;
   end

   logic [54:0]          m2_sqx_ff, m2_sqy_ff;
   logic signed [55:0]   sqx, sqy;
   logic [55:0]          r2sum;
   logic [30:0]          m3_r2_ff;
   logic [61:0]          m4_r2sq_ff;
   logic signed [47:0]   m4_k1r2_ff, m5_k1r2_ff;
   logic signed [54:0]   m5_k2r4_ff;
   logic signed [55:0]   fac, facs;
   logic signed [FW-1:0] fac_c, m6_fac_ff;
   logic                 fac_sat;
   logic signed [63:0]   prodx, prody, m7_px_ff, m7_py_ff;
   logic signed [56:0]   m8_pu_ff, m8_pv_ff;
   logic signed [39:0]   xd, yd;
   logic signed [57:0]   usum, vsum;
   logic signed [31:0]   uc, vc;
   logic                 usat, vsat;
   lpp_pkg::rsp_type     m9_in, m9_ff;

   always_comb begin
      sqx   = m1_ff.xn * m1_ff.xn;
      sqy   = m1_ff.yn * m1_ff.yn;
      r2sum = 56'(m2_sqx_ff) + 56'(m2_sqy_ff);
      fac   = (56'sd1 <<< 36) + 56'(m5_k1r2_ff) + 56'(m5_k2r4_ff);
      facs  = fac >>> 12;
      fac_sat = 1'b0;
      if (facs > 56'(lpp_pkg::FAC_MAX)) begin
         fac_c   = lpp_pkg::FAC_MAX;
         fac_sat = 1'b1;
      end else if (facs < -56'(lpp_pkg::FAC_MAX)) begin
         fac_c   = -lpp_pkg::FAC_MAX;
         fac_sat = 1'b1;
      end else begin
         fac_c   = FW'(facs);
      end
      prodx = 64'(m6_ff.xn) * 64'(m6_fac_ff);
      prody = 64'(m6_ff.yn) * 64'(m6_fac_ff);
      xd    = m7_px_ff[63:24];
      yd    = m7_py_ff[63:24];
      usum  = 58'(m8_pu_ff >>> 12) + $signed({30'b0, cx, 12'b0});
      vsum  = 58'(m8_pv_ff >>> 12) + $signed({30'b0, cy, 12'b0});
      usat  = (usum > 58'sd2147483647) || (usum < -58'sd2147483648);
      vsat  = (vsum > 58'sd2147483647) || (vsum < -58'sd2147483648);
      if (usum > 58'sd2147483647) begin
         uc = 32'sh7fffffff;
      end else if (usum < -58'sd2147483648) begin
         uc = 32'sh80000000;
      end else begin
         uc = usum[31:0];
      end
      if (vsum > 58'sd2147483647) begin
         vc = 32'sh7fffffff;
      end else if (vsum < -58'sd2147483648) begin
         vc = 32'sh80000000;
      end else begin
         vc = vsum[31:0];
      end
      if (m8_ff.err != lpp_pkg::ST_OK) begin
         m9_in.pixel_u = '0;
         m9_in.pixel_v = '0;
         m9_in.status  = m8_ff.err;
      end else begin
         m9_in.pixel_u = uc;
         m9_in.pixel_v = vc;
         m9_in.status  = (m8_ff.sat || usat || vsat) ? lpp_pkg::ST_SAT : lpp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff      <= m1_in;
         m2_sqx_ff  <= sqx[54:0];
         m2_sqy_ff  <= sqy[54:0];
         m2_ff      <= m1_ff;
         m3_r2_ff   <= r2sum[54:24];
         m3_ff      <= m2_ff;
         m4_r2sq_ff <= 62'(m3_r2_ff) * 62'(m3_r2_ff);
         m4_k1r2_ff <= k1 * $signed({1'b0, m3_r2_ff});
         m4_ff      <= m3_ff;
         m5_k2r4_ff <= k2 * $signed({1'b0, m4_r2sq_ff[61:24]});
         m5_k1r2_ff <= m4_k1r2_ff;
         m5_ff      <= m4_ff;
         m6_fac_ff  <= fac_c;
         m6_ff      <= '{xn: m5_ff.xn, yn: m5_ff.yn, err: m5_ff.err,
                         sat: m5_ff.sat || fac_sat};
         m7_px_ff   <= prodx;
         m7_py_ff   <= prody;
         m7_ff      <= m6_ff;
         m8_pu_ff   <= $signed({1'b0, fx}) * xd;
         m8_pv_ff   <= $signed({1'b0, fy}) * yd;
         m8_ff      <= m7_ff;
         m9_ff      <= m9_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
         m5_valid_ff <= 1'b0;
         m6_valid_ff <= 1'b0;
         m7_valid_ff <= 1'b0;
         m8_valid_ff <= 1'b0;
         m9_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         m1_valid_ff <= dv_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
         m5_valid_ff <= m4_valid_ff;
         m6_valid_ff <= m5_valid_ff;
         m7_valid_ff <= m6_valid_ff;
         m8_valid_ff <= m7_valid_ff;
         m9_valid_ff <= m8_valid_ff;
      end
   end

   // ---------------- output register and skid ----------------
   logic             out_valid_ff;
   lpp_pkg::rsp_type out_ff, skid_ff;
   logic             fire;
   assign fire = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || fire) begin
         out_valid_ff <= m9_valid_ff;
      end else if (m9_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (fire) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || fire) begin
         out_ff <= m9_ff;
      end else begin
         skid_ff <= m9_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: sv/lpp_chk.sv
// Port-level checker for the projection block, bound to the top level.
// Depends on lpp_pkg and the assertion macro header.
`include "lidar_point_to_pixel_projection_top_assert.svh"

module lpp_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input lpp_pkg::req_type           req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input lpp_pkg::rsp_type           rsp_data,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pwrite,
   input logic [lpp_pkg::ADDR_W-1:0] csr_paddr,
   input logic [lpp_pkg::DATA_W-1:0] csr_pwdata,
   input logic [lpp_pkg::DATA_W-1:0] csr_prdata,
   input logic                       csr_pready
);

   `LPP_ASSERT_RESET(a_reset_idle, !rsp_valid && !req_stall, "outputs not idle after reset")

   `LPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled transaction changed")

   `LPP_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_data.status == lpp_pkg::ST_NO_XFORM || rsp_data.status == lpp_pkg::ST_DEPTH), rsp_data.pixel_u == 0 && rsp_data.pixel_v == 0, "error transaction carries nonzero pixel")

   `LPP_ASSERT_NEXT(a_skid_drain, req_stall && !rsp_stall, !req_stall, "skid not drained after output taken")

endmodule

bind lidar_point_to_pixel_projection_top lpp_chk u_lpp_chk (.*);
